@@ src/soeb_pkg.sv @@
// Shared constants, step positions and helper functions for the oriented box selector.
package soeb_pkg;

  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned CntW     = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned IdxW     = 6;

  localparam int unsigned CoordW = 21;
  localparam int unsigned DiffW  = 22;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned SizeW  = 20;
  localparam int unsigned VolW   = 60;
  localparam int unsigned QprodW = 32;
  localparam int unsigned MatW   = 34;
  localparam int unsigned ProdW  = MatW + DiffW;

  localparam logic [1:0] CfgListenerX       = 2'd0;
  localparam logic [1:0] CfgListenerY       = 2'd1;
  localparam logic [1:0] CfgListenerZ       = 2'd2;
  localparam logic [1:0] CfgListenerPresent = 2'd3;

  localparam int unsigned StepW = 5;

  localparam logic [StepW-1:0] StSizeXY   = StepW'(2);
  localparam logic [StepW-1:0] StWw       = StepW'(3);
  localparam logic [StepW-1:0] StXx       = StepW'(4);
  localparam logic [StepW-1:0] StVolLo    = StepW'(5);
  localparam logic [StepW-1:0] StVolHi    = StepW'(6);
  localparam logic [StepW-1:0] StYy       = StepW'(7);
  localparam logic [StepW-1:0] StZz       = StepW'(8);
  localparam logic [StepW-1:0] StXy       = StepW'(9);
  localparam logic [StepW-1:0] StWz       = StepW'(10);
  localparam logic [StepW-1:0] StXz       = StepW'(11);
  localparam logic [StepW-1:0] StWy       = StepW'(12);
  localparam logic [StepW-1:0] StYz       = StepW'(13);
  localparam logic [StepW-1:0] StWx       = StepW'(14);
  localparam logic [StepW-1:0] StRowX     = StepW'(17);
  localparam logic [StepW-1:0] StRowY     = StepW'(20);
  localparam logic [StepW-1:0] StRowZ     = StepW'(23);
  localparam logic [StepW-1:0] StRowEnd   = StepW'(25);
  localparam logic [StepW-1:0] StTestX    = StepW'(20);
  localparam logic [StepW-1:0] StTestY    = StepW'(23);
  localparam logic [StepW-1:0] StLast     = StepW'(26);

  function automatic logic signed [MatW-1:0] ext_mat(input logic signed [QprodW-1:0] v);
    ext_mat = {{(MatW - QprodW){v[QprodW-1]}}, v};
  endfunction

  function automatic logic axis_ok(input logic signed [ProdW-1:0] r,
                                   input logic [SizeW-1:0] size);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] lhs;
    logic [ProdW-1:0] rhs;
    mag = r[ProdW-1] ? ProdW'(-r) : ProdW'(r);
    lhs = {mag[ProdW-2:0], 1'b0};
    rhs = {{(ProdW - SizeW - 28){1'b0}}, size, 28'd0};
    axis_ok = (lhs <= rhs);
  endfunction

endpackage

@@ src/soeb_mul.sv @@
// Shared signed multiplier with a registered product.
module soeb_mul
  import soeb_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MatW-1:0]  a_i,
  input  logic signed [DiffW-1:0] b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

@@ src/smallest_enclosing_oriented_box.sv @@
// Top level of the smallest enclosing oriented box selector.
// Each box beat is taken while the block is idle and then worked on by one shared
// 34 x 22 bit multiplier under a step counter, so no new box is taken until the previous
// one is done. The multiplier forms the box volume (three products), the ten quaternion
// products and the nine rotation products in turn; the containment test and the
// smallest-volume update follow as the rows finish. On the box marked last the result
// beat is loaded into an output register; the next box is taken while it waits.
module smallest_enclosing_oriented_box
  import soeb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  input  logic                     box_valid_i,
  output logic                     box_ready_o,
  input  logic signed [CoordW-1:0] box_cx_i,
  input  logic signed [CoordW-1:0] box_cy_i,
  input  logic signed [CoordW-1:0] box_cz_i,
  input  logic signed [QuatW-1:0]  quat_w_i,
  input  logic signed [QuatW-1:0]  quat_x_i,
  input  logic signed [QuatW-1:0]  quat_y_i,
  input  logic signed [QuatW-1:0]  quat_z_i,
  input  logic [SizeW-1:0]         size_x_i,
  input  logic [SizeW-1:0]         size_y_i,
  input  logic [SizeW-1:0]         size_z_i,
  input  logic                     last_box_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     found_o,
  output logic [IdxW-1:0]          box_index_o,
  output logic [VolW-1:0]          volume_x8_o
);

  typedef enum logic {StIdle, StRun} state_e;

  state_e state_q;
  logic [StepW-1:0] step_q;

  logic signed [CoordW-1:0] lx_q, ly_q, lz_q;
  logic present_q;

  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [QuatW-1:0] qw_q, qx_q, qy_q, qz_q;
  logic [SizeW-1:0] sx_q, sy_q, sz_q;
  logic last_q;

  logic signed [QprodW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic [2*SizeW-1:0] vp_q;
  logic [VolW-1:0] vol_q;
  logic signed [ProdW-1:0] acc_q;
  logic inside_q;

  logic best_valid_q;
  logic [CntW-1:0] best_index_q;
  logic [VolW-1:0] best_volume_q;
  logic [CntW-1:0] count_q;

  logic out_valid_q;
  logic found_q;
  logic [IdxW-1:0] index_q;
  logic [VolW-1:0] volume_q;

  logic signed [MatW-1:0] opa_q, opa_d;
  logic signed [DiffW-1:0] opb_q, opb_d;
  logic signed [ProdW-1:0] prod;

  logic signed [MatW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  logic inside_fin;
  logic take;
  logic best_valid_d;
  logic [CntW-1:0] best_index_d;
  logic [VolW-1:0] best_volume_d;
  logic out_free;
  logic stall;
  logic load_res;

  soeb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .p_o   (prod)
  );

  always_comb begin
    r00 = ext_mat(ww_q) + ext_mat(xx_q) - ext_mat(yy_q) - ext_mat(zz_q);
    r11 = ext_mat(ww_q) - ext_mat(xx_q) + ext_mat(yy_q) - ext_mat(zz_q);
    r22 = ext_mat(ww_q) - ext_mat(xx_q) - ext_mat(yy_q) + ext_mat(zz_q);
    r01 = (ext_mat(xy_q) - ext_mat(wz_q)) <<< 1;
    r10 = (ext_mat(xy_q) + ext_mat(wz_q)) <<< 1;
    r02 = (ext_mat(xz_q) + ext_mat(wy_q)) <<< 1;
    r20 = (ext_mat(xz_q) - ext_mat(wy_q)) <<< 1;
    r12 = (ext_mat(yz_q) - ext_mat(wx_q)) <<< 1;
    r21 = (ext_mat(yz_q) + ext_mat(wx_q)) <<< 1;
  end

  // Operand table: one product is started per step.
  always_comb begin
    opa_d = '0;
    opb_d = '0;
    case (step_q)
      5'd0: begin
        opa_d = {{(MatW - SizeW){1'b0}}, sx_q};
        opb_d = {{(DiffW - SizeW){1'b0}}, sy_q};
      end
      5'd1: begin
        opa_d = {{(MatW - QuatW){qw_q[QuatW-1]}}, qw_q};
        opb_d = {{(DiffW - QuatW){qw_q[QuatW-1]}}, qw_q};
      end
      5'd2: begin
        opa_d = {{(MatW - QuatW){qx_q[QuatW-1]}}, qx_q};
        opb_d = {{(DiffW - QuatW){qx_q[QuatW-1]}}, qx_q};
      end
      5'd3: begin
        opa_d = {{(MatW - SizeW){1'b0}}, vp_q[SizeW-1:0]};
        opb_d = {{(DiffW - SizeW){1'b0}}, sz_q};
      end
      5'd4: begin
        opa_d = {{(MatW - SizeW){1'b0}}, vp_q[2*SizeW-1:SizeW]};
        opb_d = {{(DiffW - SizeW){1'b0}}, sz_q};
      end
      5'd5: begin
        opa_d = {{(MatW - QuatW){qy_q[QuatW-1]}}, qy_q};
        opb_d = {{(DiffW - QuatW){qy_q[QuatW-1]}}, qy_q};
      end
      5'd6: begin
        opa_d = {{(MatW - QuatW){qz_q[QuatW-1]}}, qz_q};
        opb_d = {{(DiffW - QuatW){qz_q[QuatW-1]}}, qz_q};
      end
      5'd7: begin
        opa_d = {{(MatW - QuatW){qx_q[QuatW-1]}}, qx_q};
        opb_d = {{(DiffW - QuatW){qy_q[QuatW-1]}}, qy_q};
      end
      5'd8: begin
        opa_d = {{(MatW - QuatW){qw_q[QuatW-1]}}, qw_q};
        opb_d = {{(DiffW - QuatW){qz_q[QuatW-1]}}, qz_q};
      end
      5'd9: begin
        opa_d = {{(MatW - QuatW){qx_q[QuatW-1]}}, qx_q};
        opb_d = {{(DiffW - QuatW){qz_q[QuatW-1]}}, qz_q};
      end
      5'd10: begin
        opa_d = {{(MatW - QuatW){qw_q[QuatW-1]}}, qw_q};
        opb_d = {{(DiffW - QuatW){qy_q[QuatW-1]}}, qy_q};
      end
      5'd11: begin
        opa_d = {{(MatW - QuatW){qy_q[QuatW-1]}}, qy_q};
        opb_d = {{(DiffW - QuatW){qz_q[QuatW-1]}}, qz_q};
      end
      5'd12: begin
        opa_d = {{(MatW - QuatW){qw_q[QuatW-1]}}, qw_q};
        opb_d = {{(DiffW - QuatW){qx_q[QuatW-1]}}, qx_q};
      end
      5'd15: begin opa_d = r00; opb_d = dx_q; end
      5'd16: begin opa_d = r01; opb_d = dy_q; end
      5'd17: begin opa_d = r02; opb_d = dz_q; end
      5'd18: begin opa_d = r10; opb_d = dx_q; end
      5'd19: begin opa_d = r11; opb_d = dy_q; end
      5'd20: begin opa_d = r12; opb_d = dz_q; end
      5'd21: begin opa_d = r20; opb_d = dx_q; end
      5'd22: begin opa_d = r21; opb_d = dy_q; end
      5'd23: begin opa_d = r22; opb_d = dz_q; end
      default: begin
        opa_d = '0;
        opb_d = '0;
      end
    endcase
  end

  always_comb begin
    inside_fin = inside_q && axis_ok(acc_q, sz_q);
    take = inside_fin && (!best_valid_q || (vol_q <= best_volume_q));
    best_valid_d  = take ? 1'b1 : best_valid_q;
    best_index_d  = take ? count_q : best_index_q;
    best_volume_d = take ? vol_q : best_volume_q;
    out_free = !out_valid_q || res_ready_i;
    stall = last_q && !out_free;
    load_res = (state_q == StRun) && (step_q == StLast) && !stall && last_q;
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
    if (state_q == StIdle) begin
      if (box_valid_i) begin
        dx_q <= {box_cx_i[CoordW-1], box_cx_i} - {lx_q[CoordW-1], lx_q};
        dy_q <= {box_cy_i[CoordW-1], box_cy_i} - {ly_q[CoordW-1], ly_q};
        dz_q <= {box_cz_i[CoordW-1], box_cz_i} - {lz_q[CoordW-1], lz_q};
        qw_q <= quat_w_i;
        qx_q <= quat_x_i;
        qy_q <= quat_y_i;
        qz_q <= quat_z_i;
        sx_q <= size_x_i;
        sy_q <= size_y_i;
        sz_q <= size_z_i;
        last_q <= last_box_i;
      end
    end else begin
      case (step_q)
        StSizeXY: vp_q <= prod[2*SizeW-1:0];
        StWw:     ww_q <= prod[QprodW-1:0];
        StXx:     xx_q <= prod[QprodW-1:0];
        StVolLo:  vol_q <= {{(VolW - 2*SizeW){1'b0}}, prod[2*SizeW-1:0]};
        StVolHi:  vol_q <= vol_q + {prod[VolW-SizeW-1:0], {SizeW{1'b0}}};
        StYy:     yy_q <= prod[QprodW-1:0];
        StZz:     zz_q <= prod[QprodW-1:0];
        StXy:     xy_q <= prod[QprodW-1:0];
        StWz:     wz_q <= prod[QprodW-1:0];
        StXz:     xz_q <= prod[QprodW-1:0];
        StWy:     wy_q <= prod[QprodW-1:0];
        StYz:     yz_q <= prod[QprodW-1:0];
        StWx:     wx_q <= prod[QprodW-1:0];
        default: ;
      endcase
      if (step_q == StRowX || step_q == StRowY || step_q == StRowZ) begin
        acc_q <= prod;
      end else if (step_q > StRowX && step_q <= StRowEnd) begin
        acc_q <= acc_q + prod;
      end
      if (step_q == StTestX) begin
        inside_q <= axis_ok(acc_q, sx_q);
      end else if (step_q == StTestY) begin
        inside_q <= inside_q && axis_ok(acc_q, sy_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      step_q        <= '0;
      lx_q          <= '0;
      ly_q          <= '0;
      lz_q          <= '0;
      present_q     <= 1'b0;
      best_valid_q  <= 1'b0;
      best_index_q  <= '0;
      best_volume_q <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      found_q       <= 1'b0;
      index_q       <= '0;
      volume_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgListenerX:       lx_q <= cfg_data_i;
          CfgListenerY:       ly_q <= cfg_data_i;
          CfgListenerZ:       lz_q <= cfg_data_i;
          CfgListenerPresent: present_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (box_valid_i) begin
            state_q <= StRun;
            step_q  <= '0;
          end
        end
        StRun: begin
          if (step_q != StLast) begin
            step_q <= step_q + StepW'(1);
          end else if (!stall) begin
            state_q <= StIdle;
            step_q  <= '0;
            if (last_q) begin
              found_q       <= best_valid_d && present_q;
              index_q       <= (best_valid_d && present_q) ? IdxW'(best_index_d) : '0;
              volume_q      <= (best_valid_d && present_q) ? best_volume_d : '0;
              best_valid_q  <= 1'b0;
              best_index_q  <= '0;
              best_volume_q <= '0;
              count_q       <= '0;
            end else begin
              best_valid_q  <= best_valid_d;
              best_index_q  <= best_index_d;
              best_volume_q <= best_volume_d;
              count_q <= (count_q == CntW'(MaxBoxes - 1)) ? '0 : count_q + CntW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
          step_q  <= '0;
        end
      endcase
    end
  end

  assign box_ready_o = (state_q == StIdle);
  assign res_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign box_index_o = index_q;
  assign volume_x8_o = volume_q;

endmodule

@@ bench/box_choice_checker.sv @@
// Watches the box and report channels of the oriented box selector, predicts each report and compares.
module box_choice_checker
  import soeb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  input  logic                     box_valid_i,
  input  logic                     box_ready_i,
  input  logic signed [CoordW-1:0] box_cx_i,
  input  logic signed [CoordW-1:0] box_cy_i,
  input  logic signed [CoordW-1:0] box_cz_i,
  input  logic signed [QuatW-1:0]  quat_w_i,
  input  logic signed [QuatW-1:0]  quat_x_i,
  input  logic signed [QuatW-1:0]  quat_y_i,
  input  logic signed [QuatW-1:0]  quat_z_i,
  input  logic [SizeW-1:0]         size_x_i,
  input  logic [SizeW-1:0]         size_y_i,
  input  logic [SizeW-1:0]         size_z_i,
  input  logic                     last_box_i,
  input  logic                     res_valid_i,
  input  logic                     res_ready_i,
  input  logic                     found_i,
  input  logic [IdxW-1:0]          box_index_i,
  input  logic [VolW-1:0]          volume_x8_i,
  output int                       fail_count_o,
  output int                       awaited_o,
  output int                       reports_seen_o
);

  typedef struct {
    logic            found;
    logic [IdxW-1:0] index;
    logic [VolW-1:0] volume;
  } report_t;

  report_t awaited_reports[$];

  logic signed [CoordW-1:0] lis_x;
  logic signed [CoordW-1:0] lis_y;
  logic signed [CoordW-1:0] lis_z;
  logic                     lis_present;
  logic [CntW-1:0]          list_pos;
  logic                     best_hit;
  logic [IdxW-1:0]          best_idx;
  logic [VolW-1:0]          best_vol;

  function automatic logic fits_axis(input longint r, input logic [SizeW-1:0] extent);
    longint mag;
    mag = (r < 0) ? -r : r;
    return (2 * mag) <= (longint'(extent) <<< 28);
  endfunction

  task automatic score_box();
    longint dx, dy, dz, w, x, y, z, ww, xx, yy, zz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint rx, ry, rz;
    logic [VolW-1:0] vol;
    logic hit;
    report_t rep;
    dx = longint'(box_cx_i) - longint'(lis_x);
    dy = longint'(box_cy_i) - longint'(lis_y);
    dz = longint'(box_cz_i) - longint'(lis_z);
    w = longint'(quat_w_i);
    x = longint'(quat_x_i);
    y = longint'(quat_y_i);
    z = longint'(quat_z_i);
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    m00 = ww + xx - yy - zz;
    m01 = 2 * (x * y - w * z);
    m02 = 2 * (x * z + w * y);
    m10 = 2 * (x * y + w * z);
    m11 = ww - xx + yy - zz;
    m12 = 2 * (y * z - w * x);
    m20 = 2 * (x * z - w * y);
    m21 = 2 * (y * z + w * x);
    m22 = ww - xx - yy + zz;
    rx = m00 * dx + m01 * dy + m02 * dz;
    ry = m10 * dx + m11 * dy + m12 * dz;
    rz = m20 * dx + m21 * dy + m22 * dz;
    vol = VolW'(longint'(size_x_i) * longint'(size_y_i) * longint'(size_z_i));
    hit = fits_axis(rx, size_x_i) && fits_axis(ry, size_y_i) && fits_axis(rz, size_z_i);
    if (hit && (!best_hit || vol <= best_vol)) begin
      best_hit = 1'b1;
      best_idx = IdxW'(list_pos);
      best_vol = vol;
    end
    if (int'(list_pos) + 1 >= MaxBoxes) begin
      list_pos = '0;
    end else begin
      list_pos = list_pos + 1'b1;
    end
    if (last_box_i) begin
      rep.found  = best_hit & lis_present;
      rep.index  = rep.found ? best_idx : '0;
      rep.volume = rep.found ? best_vol : '0;
      awaited_reports.insert(awaited_reports.size(), rep);
      list_pos = '0;
      best_hit = 1'b0;
      best_idx = '0;
      best_vol = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t due;
    if (!rst_ni) begin
      awaited_reports.delete();
      lis_x = '0;
      lis_y = '0;
      lis_z = '0;
      lis_present = 1'b0;
      list_pos = '0;
      best_hit = 1'b0;
      best_idx = '0;
      best_vol = '0;
      fail_count_o = 0;
      awaited_o = 0;
      reports_seen_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        reports_seen_o++;
        if (awaited_reports.size() == 0) begin
          $error("report beat with none awaited: found %0d, box_index %0d, volume_x8 %0d",
                 found_i, box_index_i, volume_x8_i);
          fail_count_o++;
        end else begin
          due = awaited_reports.pop_front();
          if (found_i !== due.found) begin
            $error("found: expected %0d, actual %0d", due.found, found_i);
            fail_count_o++;
          end
          if (box_index_i !== due.index) begin
            $error("box_index: expected %0d, actual %0d", due.index, box_index_i);
            fail_count_o++;
          end
          if (volume_x8_i !== due.volume) begin
            $error("volume_x8: expected %0d, actual %0d", due.volume, volume_x8_i);
            fail_count_o++;
          end
        end
      end
      if (box_valid_i && box_ready_i) begin
        score_box();
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgListenerX:       lis_x = cfg_data_i;
          CfgListenerY:       lis_y = cfg_data_i;
          CfgListenerZ:       lis_z = cfg_data_i;
          CfgListenerPresent: lis_present = cfg_data_i[0];
          default:            ;
        endcase
      end
      awaited_o = awaited_reports.size();
    end
  end

endmodule

@@ bench/smallest_enclosing_oriented_box_test.sv @@
// Stimulus, idling and verdict for the smallest enclosing oriented box selector.
module smallest_enclosing_oriented_box_test;
  import soeb_pkg::*;

  localparam int MinC       = -1048576;
  localparam int MaxC       = 1048575;
  localparam int MaxS       = 1048575;
  localparam int UnitQ      = 16384;
  localparam int HalfQ      = 8192;
  localparam int Settle     = 40;
  localparam int HoldCycles = 800;

  typedef struct {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic signed [QuatW-1:0]  qw;
    logic signed [QuatW-1:0]  qx;
    logic signed [QuatW-1:0]  qy;
    logic signed [QuatW-1:0]  qz;
    logic [SizeW-1:0]         sx;
    logic [SizeW-1:0]         sy;
    logic [SizeW-1:0]         sz;
    logic                     last;
  } box_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [CoordW-1:0]        cfg_data_i;
  logic                     box_valid_i;
  logic                     box_ready_o;
  logic signed [CoordW-1:0] box_cx_i;
  logic signed [CoordW-1:0] box_cy_i;
  logic signed [CoordW-1:0] box_cz_i;
  logic signed [QuatW-1:0]  quat_w_i;
  logic signed [QuatW-1:0]  quat_x_i;
  logic signed [QuatW-1:0]  quat_y_i;
  logic signed [QuatW-1:0]  quat_z_i;
  logic [SizeW-1:0]         size_x_i;
  logic [SizeW-1:0]         size_y_i;
  logic [SizeW-1:0]         size_z_i;
  logic                     last_box_i;
  logic                     res_valid_o;
  logic                     res_ready_i = 1'b0;
  logic                     found_o;
  logic [IdxW-1:0]          box_index_o;
  logic [VolW-1:0]          volume_x8_o;

  int fail_count;
  int awaited;
  int reports_seen;
  int snd_idle_pct = 36;
  int rcv_idle_pct = 86;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int boxes_sent = 0;
  int lists_sent = 0;
  int settings_used = 0;
  int lis_x = 0;
  int lis_y = 0;
  int lis_z = 0;

  always #5 clk_i = ~clk_i;

  smallest_enclosing_oriented_box uut (.*);

  box_choice_checker choice_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .box_valid_i   (box_valid_i),
    .box_ready_i   (box_ready_o),
    .box_cx_i      (box_cx_i),
    .box_cy_i      (box_cy_i),
    .box_cz_i      (box_cz_i),
    .quat_w_i      (quat_w_i),
    .quat_x_i      (quat_x_i),
    .quat_y_i      (quat_y_i),
    .quat_z_i      (quat_z_i),
    .size_x_i      (size_x_i),
    .size_y_i      (size_y_i),
    .size_z_i      (size_z_i),
    .last_box_i    (last_box_i),
    .res_valid_i   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .found_i       (found_o),
    .box_index_i   (box_index_o),
    .volume_x8_i   (volume_x8_o),
    .fail_count_o  (fail_count),
    .awaited_o     (awaited),
    .reports_seen_o(reports_seen)
  );

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic logic signed [CoordW-1:0] clamp_coord(input int v);
    if (v > MaxC) return CoordW'(MaxC);
    if (v < MinC) return CoordW'(MinC);
    return CoordW'(v);
  endfunction

  function automatic int pick_coord();
    logic signed [CoordW-1:0] c;
    c = CoordW'($urandom);
    case ($urandom_range(7))
      0:       return MinC;
      1:       return MaxC;
      2:       return 0;
      default: return int'(c);
    endcase
  endfunction

  function automatic box_t mk_box(input int cx, input int cy, input int cz, input int qw,
                                  input int qx, input int qy, input int qz, input int sx,
                                  input int sy, input int sz, input logic last);
    box_t b;
    b.cx = CoordW'(cx);
    b.cy = CoordW'(cy);
    b.cz = CoordW'(cz);
    b.qw = QuatW'(qw);
    b.qx = QuatW'(qx);
    b.qy = QuatW'(qy);
    b.qz = QuatW'(qz);
    b.sx = SizeW'(sx);
    b.sy = SizeW'(sy);
    b.sz = SizeW'(sz);
    b.last = last;
    return b;
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    int k;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return SizeW'(1024);
        1:       return SizeW'(4096);
        2:       return SizeW'(65536);
        default: return SizeW'(262144);
      endcase
    end
    k = $urandom_range(4, 20);
    return SizeW'($urandom & ((1 << k) - 1));
  endfunction

  // A box placed near the listener with a mostly unit rotation, so that containment is common.
  function automatic box_t near_box(input logic last);
    box_t b;
    int reach;
    int pick;
    int sgn;
    int i;
    int qv[4];
    for (i = 0; i < 4; i++) qv[i] = 0;
    reach = 1 << $urandom_range(12);
    pick = $urandom_range(9);
    sgn = $urandom_range(1) ? UnitQ : -UnitQ;
    if (pick < 4) begin
      qv[pick] = sgn;
    end else if (pick < 7) begin
      for (i = 0; i < 4; i++) qv[i] = $urandom_range(1) ? HalfQ : -HalfQ;
    end else if (pick == 7) begin
      qv[0] = 11585;
      qv[$urandom_range(1, 3)] = (sgn > 0) ? 11585 : -11585;
    end else begin
      for (i = 0; i < 4; i++) qv[i] = int'($urandom_range(2 * UnitQ)) - UnitQ;
    end
    b.cx = clamp_coord(lis_x + int'($urandom_range(2 * reach)) - reach);
    b.cy = clamp_coord(lis_y + int'($urandom_range(2 * reach)) - reach);
    b.cz = clamp_coord(lis_z + int'($urandom_range(2 * reach)) - reach);
    b.qw = QuatW'(qv[0]);
    b.qx = QuatW'(qv[1]);
    b.qy = QuatW'(qv[2]);
    b.qz = QuatW'(qv[3]);
    b.sx = rand_size();
    b.sy = rand_size();
    b.sz = rand_size();
    b.last = last;
    return b;
  endfunction

  function automatic box_t noise_box(input logic last);
    box_t b;
    b.cx = CoordW'($urandom);
    b.cy = CoordW'($urandom);
    b.cz = CoordW'($urandom);
    b.qw = QuatW'(int'($urandom_range(2 * UnitQ)) - UnitQ);
    b.qx = QuatW'(int'($urandom_range(2 * UnitQ)) - UnitQ);
    b.qy = QuatW'(int'($urandom_range(2 * UnitQ)) - UnitQ);
    b.qz = QuatW'(int'($urandom_range(2 * UnitQ)) - UnitQ);
    b.sx = SizeW'($urandom);
    b.sy = SizeW'($urandom);
    b.sz = SizeW'($urandom);
    b.last = last;
    return b;
  endfunction

  task automatic send_box(input box_t b);
    while ($urandom_range(99) < snd_idle_pct) begin
      box_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    box_cx_i    <= b.cx;
    box_cy_i    <= b.cy;
    box_cz_i    <= b.cz;
    quat_w_i    <= b.qw;
    quat_x_i    <= b.qx;
    quat_y_i    <= b.qy;
    quat_z_i    <= b.qz;
    size_x_i    <= b.sx;
    size_y_i    <= b.sy;
    size_z_i    <= b.sz;
    last_box_i  <= b.last;
    box_valid_i <= 1'b1;
    do @(posedge clk_i); while (!box_ready_o);
    @(negedge clk_i);
    boxes_sent++;
    if (b.last) lists_sent++;
  endtask

  task automatic send_list(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 15) begin
        send_box(noise_box(i == len - 1));
      end else begin
        send_box(near_box(i == len - 1));
      end
    end
  endtask

  // A box that is not last may still be in flight after the final report, so wait a little longer.
  task automatic settle();
    box_valid_i <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CoordW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  task automatic move_listener(input int x, input int y, input int z, input logic present);
    settle();
    write_reg(CfgListenerX, CoordW'(x));
    write_reg(CfgListenerY, CoordW'(y));
    write_reg(CfgListenerZ, CoordW'(z));
    write_reg(CfgListenerPresent, CoordW'(present));
    cfg_we_i <= 1'b0;
    lis_x = x;
    lis_y = y;
    lis_z = z;
    settings_used++;
  endtask

  initial begin : stimulus
    int regime;
    int phase;
    int target;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgListenerX;
    cfg_data_i  = '0;
    box_valid_i = 1'b0;
    box_cx_i    = '0;
    box_cy_i    = '0;
    box_cz_i    = '0;
    quat_w_i    = '0;
    quat_x_i    = '0;
    quat_y_i    = '0;
    quat_z_i    = '0;
    size_x_i    = '0;
    size_y_i    = '0;
    size_z_i    = '0;
    last_box_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    move_listener(0, 0, 0, 1'b1);
    send_box(mk_box(0, 0, 0, UnitQ, 0, 0, 0, 0, 0, 0, 1'b1));
    send_box(mk_box(MaxC, MinC, 0, UnitQ, 0, 0, 0, MaxS, MaxS, MaxS, 1'b1));
    send_box(mk_box(100, -100, 50, 0, UnitQ, 0, 0, 4096, 8192, 16384, 1'b0));
    send_box(mk_box(-100, 100, -50, 0, 0, -UnitQ, 0, 16384, 4096, 8192, 1'b0));
    send_box(mk_box(0, 0, 0, -UnitQ, 0, 0, 0, MaxS, MaxS, MaxS, 1'b1));
    send_box(mk_box(10, 20, 30, UnitQ, UnitQ, UnitQ, UnitQ, 2048, 2048, 2048, 1'b1));
    send_box(mk_box(5, -5, 5, 0, 0, 0, -UnitQ, 0, 256, 256, 1'b0));
    send_box(mk_box(0, 7, 0, 0, 0, 0, UnitQ, 0, 100, 100, 1'b0));
    send_box(mk_box(MinC, MaxC, MinC, HalfQ, -HalfQ, HalfQ, -HalfQ, MaxS, MaxS, MaxS, 1'b1));

    move_listener(MinC, MaxC, MinC, 1'b1);
    send_box(mk_box(MaxC, MinC, MaxC, UnitQ, 0, 0, 0, MaxS, MaxS, MaxS, 1'b0));
    send_box(mk_box(MinC, MaxC, MinC, 0, 0, UnitQ, 0, 1, 1, 1, 1'b1));

    move_listener(MaxC, MinC, MaxC, 1'b0);
    send_box(mk_box(MaxC, MinC, MaxC, UnitQ, 0, 0, 0, 512, 512, 512, 1'b1));
    send_box(mk_box(MaxC - 256, MinC + 256, MaxC, UnitQ, 0, 0, 0, 1024, 1024, 1024, 1'b0));
    move_listener(MaxC, MinC, MaxC, 1'b1);
    send_box(mk_box(0, 0, 0, UnitQ, 0, 0, 0, 1, 1, 1, 1'b1));

    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          snd_idle_pct = 36;
          rcv_idle_pct = 86;
        end
        1: begin
          snd_idle_pct = 86;
          rcv_idle_pct = 36;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (phase = 0; phase < 4; phase++) begin
        move_listener(pick_coord(), pick_coord(), pick_coord(), $urandom_range(4) != 0);
        if (regime == 2 && phase == 0) hold_token++;
        target = boxes_sent + 150;
        if (regime == 0 && phase == 0) send_list(70);
        while (boxes_sent < target) send_list($urandom_range(1, 8));
      end
    end

    settle();
    $display("Sent %0d boxes in %0d lists under %0d listener settings; %0d reports checked.",
             boxes_sent, lists_sent, settings_used, reports_seen);
    $display("Covered heavy sender idling, heavy receiver idling, none, and one long report stall.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
